// File: rtl/renc_pkg.sv
// Shared types and constants for the rotary encoder decoder.
package renc_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_THRESHOLD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_TICKS = 2'd2;

  localparam logic [6:0]  STEP_THRESHOLD_RST   = 7'd4;
  localparam logic [7:0]  DEBOUNCE_TICKS_RST   = 8'd5;
  localparam logic [15:0] LONG_PRESS_TICKS_RST = 16'd1000;

  // rotation events of one tick
  typedef struct packed {
    logic cw;
    logic ccw;
  } rot_evt_t;

  // button events of one tick
  typedef struct packed {
    logic press;
    logic release_short;
    logic release_long;
    logic long_hold;
    logic down;
  } btn_evt_t;

endpackage

// File: rtl/renc_quad.sv
// Quadrature step counter with threshold-based rotation events.
module renc_quad (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                pin_a,
  input  logic                pin_b,
  input  logic [6:0]          step_threshold,
  output renc_pkg::rot_evt_t  evt
);

  logic [1:0]        ab_previous, ab_previous_next;
  logic              primed, primed_next;
  logic signed [7:0] step_count, step_count_next;

  logic [1:0]        ab;
  logic signed [7:0] count_mid;
  logic [7:0]        mag;
  logic [6:0]        thr;

  always_comb begin
    ab               = {pin_a, pin_b};
    primed_next      = 1'b1;
    ab_previous_next = ab;
    count_mid        = step_count;
    if (primed && (ab != ab_previous)) begin
      if (ab_previous[1] ^ pin_b) begin
        if (step_count != 8'sd127) count_mid = step_count + 8'sd1;
      end else begin
        if (step_count != -8'sd128) count_mid = step_count - 8'sd1;
      end
    end
    // -(-128) wraps to 8'h80, which reads correctly as unsigned 128
    mag = count_mid[7] ? 8'(-count_mid) : 8'(count_mid);
    thr = (step_threshold == 7'd0) ? 7'd1 : step_threshold;
    evt.cw          = 1'b0;
    evt.ccw         = 1'b0;
    step_count_next = count_mid;
    if (mag >= {1'b0, thr}) begin
      if (count_mid > 8'sd0) evt.cw = 1'b1;
      else evt.ccw = 1'b1;
      step_count_next = 8'sd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ab_previous <= 2'b00;
      primed      <= 1'b0;
      step_count  <= 8'sd0;
    end else if (en) begin
      ab_previous <= ab_previous_next;
      primed      <= primed_next;
      step_count  <= step_count_next;
    end
  end

endmodule

// File: rtl/renc_button.sv
// Button debounce, press/release classification and long-press detection.
module renc_button #(
  parameter int unsigned HOLD_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                pin_button,
  input  logic [7:0]          debounce_ticks,
  input  logic [15:0]         long_press_ticks,
  output renc_pkg::btn_evt_t  evt
);

  localparam int unsigned CMP_W = (HOLD_BITS > 16) ? HOLD_BITS : 16;
  localparam logic [HOLD_BITS-1:0] HOLD_MAX = {HOLD_BITS{1'b1}};

  logic                 pressed_state, pressed_state_next;
  logic                 long_flag, long_flag_next;
  logic [7:0]           debounce_count, debounce_count_next;
  logic [HOLD_BITS-1:0] hold_count, hold_count_next;

  logic       pin_low;
  logic [7:0] deb_inc;
  logic [CMP_W-1:0] lpt_ext;

  always_comb begin
    pin_low             = ~pin_button;
    lpt_ext             = CMP_W'(long_press_ticks);
    deb_inc             = (debounce_count == 8'hFF) ? 8'hFF : debounce_count + 8'd1;
    pressed_state_next  = pressed_state;
    long_flag_next      = long_flag;
    debounce_count_next = 8'd0;
    hold_count_next     = hold_count;
    evt.press           = 1'b0;
    evt.release_short   = 1'b0;
    evt.release_long    = 1'b0;
    evt.long_hold       = 1'b0;

    if (pin_low != pressed_state) begin
      debounce_count_next = deb_inc;
      if (deb_inc >= debounce_ticks) begin
        debounce_count_next = 8'd0;
        pressed_state_next  = ~pressed_state;
        long_flag_next      = 1'b0;
        if (!pressed_state) evt.press = 1'b1;
        else if (CMP_W'(hold_count) >= lpt_ext) evt.release_long = 1'b1;
        else evt.release_short = 1'b1;
        hold_count_next = '0;
      end
    end

    if (pressed_state_next && !long_flag_next) begin
      hold_count_next = (hold_count_next == HOLD_MAX) ? HOLD_MAX
                                                      : hold_count_next + HOLD_BITS'(1);
      if (CMP_W'(hold_count_next) >= lpt_ext) begin
        evt.long_hold  = 1'b1;
        long_flag_next = 1'b1;
      end
    end
    evt.down = pressed_state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pressed_state  <= 1'b0;
      long_flag      <= 1'b0;
      debounce_count <= 8'd0;
      hold_count     <= '0;
    end else if (en) begin
      pressed_state  <= pressed_state_next;
      long_flag      <= long_flag_next;
      debounce_count <= debounce_count_next;
      hold_count     <= hold_count_next;
    end
  end

endmodule

// File: rtl/rotary_encoder_decoder.sv
// Top level: input register, rotation and button logic, result register.
// Pipeline: input register, then result register; the result beat is loaded when the input sample advances.
// Throughput: one sample tick per cycle; the input register stalls only while
//   the result register is full and not taken.
// Reset (rst, synchronous): clears all decoder state, both pipeline valids, and
//   restores the configuration registers to 4 / 5 / 1000.
module rotary_encoder_decoder #(
  parameter int unsigned HOLD_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [7:0]                         s_tdata,  // pin_a, pin_b, pin_button, 0 pad
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [7:0]                         m_tdata,  // evt_cw, evt_ccw, evt_press,
                                                       // evt_release, evt_long_release,
                                                       // evt_long_hold, button_down, 0 pad
  input  logic                               cfg_we,
  input  logic [renc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [renc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [6:0]  step_threshold;
  logic [7:0]  debounce_ticks;
  logic [15:0] long_press_ticks;

  logic       in_valid;
  logic [2:0] in_pins;
  logic       advance;

  renc_pkg::rot_evt_t rot_evt;
  renc_pkg::btn_evt_t btn_evt;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_threshold   <= renc_pkg::STEP_THRESHOLD_RST;
      debounce_ticks   <= renc_pkg::DEBOUNCE_TICKS_RST;
      long_press_ticks <= renc_pkg::LONG_PRESS_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        renc_pkg::CFG_STEP_THRESHOLD:   step_threshold   <= cfg_data[6:0];
        renc_pkg::CFG_DEBOUNCE_TICKS:   debounce_ticks   <= cfg_data[7:0];
        renc_pkg::CFG_LONG_PRESS_TICKS: long_press_ticks <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_pins <= s_tdata[2:0];
    end
  end

  renc_quad u_quad (
    .clk            (clk),
    .rst            (rst),
    .en             (advance),
    .pin_a          (in_pins[0]),
    .pin_b          (in_pins[1]),
    .step_threshold (step_threshold),
    .evt            (rot_evt)
  );

  renc_button #(
    .HOLD_BITS (HOLD_BITS)
  ) u_button (
    .clk              (clk),
    .rst              (rst),
    .en               (advance),
    .pin_button       (in_pins[2]),
    .debounce_ticks   (debounce_ticks),
    .long_press_ticks (long_press_ticks),
    .evt              (btn_evt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {1'b0, btn_evt.down, btn_evt.long_hold, btn_evt.release_long,
                  btn_evt.release_short, btn_evt.press, rot_evt.ccw, rot_evt.cw};
    end
  end

endmodule

// File: rtl/renc_checker.sv
// Port-level checks for the rotary encoder decoder, bound to the top level.
module renc_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  a_rot_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
    else $error("cw and ccw in one beat");

  a_press_down: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[2] || m_tdata[5])) |-> m_tdata[6])
    else $error("press or long hold with button released");

  a_release_up: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[3] || m_tdata[4])) |-> (!m_tdata[6] && !(m_tdata[3] && m_tdata[4])))
    else $error("release beat inconsistent with button state");

  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result beat changed while stalled");

endmodule

bind rotary_encoder_decoder renc_checker u_renc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// File: test/rotary_encoder_decoder_tb.sv
`timescale 1ns / 1ps
// Testbench for the rotary encoder decoder: directed and random pin samples, checked per beat.
module rotary_encoder_decoder_tb;

  localparam int HOLD_BITS = 16;
  localparam longint unsigned HOLD_MAX = (64'd1 << HOLD_BITS) - 1;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_OFF_CYCLES = 60;
  // AB values in clockwise order, AB = {a, b}
  localparam bit [7:0] GRAY_AB = {2'b10, 2'b11, 2'b01, 2'b00};

  // Predicts the events of each pin sample and checks them against the output beats.
  class encoder_event_scoreboard;
    bit [6:0]  step_limit = renc_pkg::STEP_THRESHOLD_RST;
    bit [7:0]  bounce_limit = renc_pkg::DEBOUNCE_TICKS_RST;
    bit [15:0] hold_limit = renc_pkg::LONG_PRESS_TICKS_RST;

    bit [1:0] last_ab;
    bit ab_seen;
    int step_tally;
    bit is_down;
    bit long_done;
    int bounce_tally;
    longint unsigned hold_ticks;

    bit [7:0] expected_events[$];
    int samples, beats, errors;
    int cw_seen, ccw_seen, press_seen, rel_seen, long_rel_seen, long_hold_seen;

    function void set_reg(logic [renc_pkg::CFG_IDX_W-1:0] idx,
                          logic [renc_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        renc_pkg::CFG_STEP_THRESHOLD: step_limit = val[6:0];
        renc_pkg::CFG_DEBOUNCE_TICKS: bounce_limit = val[7:0];
        renc_pkg::CFG_LONG_PRESS_TICKS: hold_limit = val[15:0];
        default: ;
      endcase
    endfunction

    // pins = {button, b, a}
    function void note_sample(bit [2:0] pins);
      bit b, pin_low;
      bit [1:0] ab;
      int lim, mag;
      bit cw, ccw, press, rel, lrel, lhold;
      b = pins[1];
      pin_low = !pins[2];
      ab = {pins[0], pins[1]};
      lim = (step_limit == 0) ? 1 : int'(step_limit);
      {cw, ccw, press, rel, lrel, lhold} = '0;

      if (!ab_seen) begin
        ab_seen = 1'b1;
        last_ab = ab;
      end else if (ab != last_ab) begin
        if (last_ab[1] ^ b) begin
          if (step_tally < 127) step_tally++;
        end else begin
          if (step_tally > -128) step_tally--;
        end
        last_ab = ab;
      end
      mag = (step_tally < 0) ? -step_tally : step_tally;
      if (mag >= lim) begin
        if (step_tally > 0) cw = 1'b1;
        else ccw = 1'b1;
        step_tally = 0;
      end

      if (pin_low != is_down) begin
        if (bounce_tally < 255) bounce_tally++;
        if (bounce_tally >= int'(bounce_limit)) begin
          bounce_tally = 0;
          is_down = !is_down;
          long_done = 1'b0;
          if (is_down) press = 1'b1;
          else if (hold_ticks >= hold_limit) lrel = 1'b1;
          else rel = 1'b1;
          hold_ticks = 0;
        end
      end else begin
        bounce_tally = 0;
      end

      if (is_down && !long_done) begin
        if (hold_ticks < HOLD_MAX) hold_ticks++;
        if (hold_ticks >= hold_limit) begin
          lhold = 1'b1;
          long_done = 1'b1;
        end
      end

      samples++;
      cw_seen += int'(cw);
      ccw_seen += int'(ccw);
      press_seen += int'(press);
      rel_seen += int'(rel);
      long_rel_seen += int'(lrel);
      long_hold_seen += int'(lhold);
      expected_events.push_back({1'b0, is_down, lhold, lrel, rel, press, ccw, cw});
    endfunction

    function void check_events(logic [7:0] got);
      bit [7:0] want;
      if (expected_events.size() == 0) begin
        errors++;
        $display("%0t: result beat %b with no sample outstanding", $time, got);
        return;
      end
      want = expected_events.pop_front();
      beats++;
      if (got !== want) begin
        errors++;
        $display({"%0t: beat %0d mismatch: expected cw=%b ccw=%b press=%b rel=%b ",
                  "long_rel=%b long_hold=%b down=%b pad=%b, got cw=%b ccw=%b press=%b ",
                  "rel=%b long_rel=%b long_hold=%b down=%b pad=%b"},
                 $time, beats, want[0], want[1], want[2], want[3], want[4], want[5],
                 want[6], want[7], got[0], got[1], got[2], got[3], got[4], got[5],
                 got[6], got[7]);
      end
    endfunction

    function int pending();
      return expected_events.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic [7:0] s_tdata = '0;
  logic m_tready = 1'b0;
  logic cfg_we = 1'b0;
  logic [renc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [renc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  wire s_tready;
  wire m_tvalid;
  wire [7:0] m_tdata;

  encoder_event_scoreboard sb;
  bit idle_en = 1'b1;
  bit hold_off_pending = 1'b0;
  int gray_pos = 0;
  bit rot_up = 1'b1;
  bit btn_level = 1'b1;
  int btn_run = 0;
  int cycle_count = 0;

  rotary_encoder_decoder #(.HOLD_BITS(HOLD_BITS)) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Called and returning at a falling edge; valid stays up when the next beat follows at once.
  task automatic send_code(input bit [2:0] code);
    int gap;
    gap = idle_en ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {5'b0, code};
    do @(posedge clk); while (s_tready !== 1'b1);
    sb.note_sample(code);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  task automatic set_config(input logic [15:0] thr, input logic [15:0] db,
                            input logic [15:0] lp);
    cfg_we <= 1'b1;
    cfg_index <= renc_pkg::CFG_STEP_THRESHOLD;
    cfg_data <= thr;
    @(negedge clk);
    cfg_index <= renc_pkg::CFG_DEBOUNCE_TICKS;
    cfg_data <= db;
    @(negedge clk);
    cfg_index <= renc_pkg::CFG_LONG_PRESS_TICKS;
    cfg_data <= lp;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(renc_pkg::CFG_STEP_THRESHOLD, thr);
    sb.set_reg(renc_pkg::CFG_DEBOUNCE_TICKS, db);
    sb.set_reg(renc_pkg::CFG_LONG_PRESS_TICKS, lp);
  endtask

  // Mostly clean quadrature walks and held button levels; some jumps and bounces.
  task automatic run_random(input int count);
    int db_eff, lp_eff, r;
    bit [1:0] ab;
    db_eff = (sb.bounce_limit == 0) ? 1 : int'(sb.bounce_limit);
    lp_eff = (sb.hold_limit > 150) ? 150 :
             ((sb.hold_limit == 0) ? 1 : int'(sb.hold_limit));
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 6) rot_up = !rot_up;
      if (r < 80) gray_pos = (gray_pos + (rot_up ? 1 : 3)) % 4;
      else if (r >= 92) gray_pos = $urandom_range(0, 3);
      if (btn_run == 0) begin
        btn_level = !btn_level;
        if ($urandom_range(0, 99) < 20) btn_run = $urandom_range(1, db_eff);
        else btn_run = $urandom_range(db_eff, db_eff + 2 * lp_eff + 4);
      end
      btn_run--;
      ab = GRAY_AB[2*gray_pos +: 2];
      send_code({btn_level, ab[0], ab[1]});
    end
  endtask

  // result side: random stall per beat, one long hold-off on request
  initial begin
    int gap;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end
      gap = idle_en ? $urandom_range(0, 4) : 0;
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      sb.check_events(m_tdata);
      @(negedge clk);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    bit [2:0] pattern[$];
    bit [1:0] ab;
    logic [15:0] thr, db, lp;
    sb = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: first sample only primes AB, a clockwise and a counter-clockwise
    // detent, press and short release, a double step jump
    pattern = '{3'd3, 3'd1, 3'd0, 3'd2, 3'd3, 3'd7, 3'd6, 3'd4, 3'd5, 3'd7, 3'd4};
    foreach (pattern[k]) send_code(pattern[k]);
    run_random(200);

    // zero settings behave like one: press with long hold in the same beat
    wait_idle();
    set_config(16'd0, 16'd0, 16'd0);
    pattern = '{3'd0, 3'd5, 3'd2, 3'd6, 3'd1};
    foreach (pattern[k]) send_code(pattern[k]);

    wait_idle();
    set_config(16'd1, 16'd1, 16'd1);
    pattern = '{3'd0, 3'd4, 3'd0, 3'd0, 3'd4, 3'd7};
    foreach (pattern[k]) send_code(pattern[k]);

    for (int k = 0; k < 7; k++) begin
      wait_idle();
      thr = (k == 0) ? 16'd1 : (k == 1) ? 16'd64 : 16'($urandom_range(1, 8));
      db = (k == 2) ? 16'd1 : 16'($urandom_range(1, 8));
      lp = (k == 2) ? 16'd1 : 16'($urandom_range(1, 40));
      set_config(thr, db, lp);
      if (k == 3) hold_off_pending = 1'b1;
      run_random(65);
    end

    // upper extremes: slowest debounce with a coarse threshold of 64 while turning,
    // press, long hold, then a long release
    wait_idle();
    set_config(16'd64, 16'd255, 16'd40);
    idle_en = 1'b0;
    repeat (300) begin
      gray_pos = (gray_pos + 1) % 4;
      ab = GRAY_AB[2*gray_pos +: 2];
      send_code({1'b0, ab[0], ab[1]});
    end
    repeat (260) begin
      gray_pos = (gray_pos + 3) % 4;
      ab = GRAY_AB[2*gray_pos +: 2];
      send_code({1'b1, ab[0], ab[1]});
    end
    idle_en = 1'b1;

    wait_idle();
    repeat (4) @(posedge clk);
    $display("ran %0d pin samples over several threshold settings, %0d beats checked, %0d errors",
             sb.samples, sb.beats, sb.errors);
    $display("events: cw %0d ccw %0d press %0d release %0d long release %0d long hold %0d",
             sb.cw_seen, sb.ccw_seen, sb.press_seen, sb.rel_seen, sb.long_rel_seen,
             sb.long_hold_seen);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
